// ===== src/bpc_pkg.sv =====
package bpc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] REG_TEMP_CAL   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_CAL = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SCALE_CAL  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_OVERSAMPLE = 2'd3;

  localparam logic [31:0] TEMP_BIAS   = 32'd4000;
  localparam logic [31:0] SCALE_BIAS  = 32'd32768;
  localparam logic [31:0] QUOT_BASE   = 32'd50000;
  localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
  localparam logic [31:0] CORR_SQ     = 32'd3038;
  localparam logic [31:0] CORR_LIN    = 32'hFFFF_E343;
  localparam logic [31:0] CORR_CONST  = 32'd3791;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               divide_fault;
  } out_t;

  typedef struct packed {
    logic [15:0] slope;
    logic [15:0] toff;
    logic [15:0] numer;
    logic [15:0] dterm;
    logic [15:0] base;
    logic [15:0] olin;
    logic [15:0] osq;
    logic [15:0] slin;
    logic [15:0] scale;
    logic [15:0] ssq;
    logic [1:0]  oss;
  } cal_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] full;
    logic [31:0] b6;
    logic [18:0] up;
    logic        fault;
  } tmp_t;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] zx16(logic [15:0] v);
    return {16'd0, v};
  endfunction

  function automatic logic [31:0] asr(logic [31:0] v, logic [4:0] n);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] mul(logic [31:0] a, logic [31:0] b);
    return a * b;
  endfunction

endpackage

// ===== src/barometric_pressure_compensation.sv =====
// Barometric pressure compensation, integer scheme.
// Input channel: in_valid/in_stall carry one request of a raw temperature
// word and a raw pressure word (in_data). Output channel: out_valid/out_stall
// carry temperature in 0.1 degree C, pressure in Pa and a divide fault flag.
// Configuration: cfg_valid/cfg_ready write register cfg_index with cfg_data:
// 0 temperature coefficients, 1 offset coefficients, 2 scale coefficients,
// 3 oversampling. cfg_ready is always high; write only while idle.
// Throughput: one request per cycle while the output is not stalled. The
// pipeline is built from two 32-stage restoring dividers (one bit per stage)
// plus the multiplier stages around them.
// The whole pipeline advances together: while out_valid is high and
// out_stall is high every stage holds and in_stall is raised; nothing is
// dropped or repeated.
// Reset clears all valid bits and the configuration registers to zero.
// A zero divisor gives divide_fault high with both results zero.
module barometric_pressure_compensation
  import bpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_t                out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [63:0] temp_cal;
  logic [47:0] offset_cal, scale_cal;
  logic [1:0]  oss;
  logic        adv;
  cal_t        cal;
  tmp_t        tmp;

  assign cfg_ready = 1'b1;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal   <= '0;
      offset_cal <= '0;
      scale_cal  <= '0;
      oss        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEMP_CAL:   temp_cal   <= cfg_data;
        REG_OFFSET_CAL: offset_cal <= cfg_data[47:0];
        REG_SCALE_CAL:  scale_cal  <= cfg_data[47:0];
        REG_OVERSAMPLE: oss        <= cfg_data[1:0];
        default:        oss        <= oss;
      endcase
    end
  end

  assign cal.slope = temp_cal[63:48];
  assign cal.toff  = temp_cal[47:32];
  assign cal.numer = temp_cal[31:16];
  assign cal.dterm = temp_cal[15:0];
  assign cal.base  = offset_cal[47:32];
  assign cal.olin  = offset_cal[31:16];
  assign cal.osq   = offset_cal[15:0];
  assign cal.slin  = scale_cal[47:32];
  assign cal.scale = scale_cal[31:16];
  assign cal.ssq   = scale_cal[15:0];
  assign cal.oss   = oss;

  bpc_temp u_temp (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .v_in    (in_valid),
    .in_data (in_data),
    .cal     (cal),
    .tmp     (tmp)
  );

  bpc_press u_press (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .tmp      (tmp),
    .cal      (cal),
    .v_out    (out_valid),
    .out_data (out_data)
  );

  a_stall_tracks_output: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_fault_zeroes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divide_fault |->
      out_data.pressure_pa == 32'sd0 && out_data.temperature_tenths == 16'sd0)
    else $error("faulted result carries nonzero values");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== src/bpc_div.sv =====
module bpc_div
  import bpc_pkg::*;
#(
  parameter int unsigned W  = DataW,
  parameter int unsigned PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          v_in,
  input  logic [W-1:0]  n_in,
  input  logic [W-1:0]  d_in,
  input  logic [PW-1:0] p_in,
  output logic          v_out,
  output logic [W-1:0]  q_out,
  output logic [PW-1:0] p_out
);

  logic [W-1:0]  rem_a [0:W];
  logic [W-1:0]  num_a [0:W];
  logic [W-1:0]  den_a [0:W];
  logic [W-1:0]  quo_a [0:W];
  logic [PW-1:0] pay_a [0:W];
  logic          vld_a [0:W];

  assign rem_a[0] = '0;
  assign num_a[0] = n_in;
  assign den_a[0] = d_in;
  assign quo_a[0] = '0;
  assign pay_a[0] = p_in;
  assign vld_a[0] = v_in;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W:0] r;
    logic [W:0] diff;
    logic       ge;
    assign r    = {rem_a[k], num_a[k][W-1]};
    assign diff = r - {1'b0, den_a[k]};
    assign ge   = (r >= {1'b0, den_a[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_a[k+1] <= 1'b0;
      end else if (adv) begin
        vld_a[k+1] <= vld_a[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_a[k+1] <= ge ? diff[W-1:0] : r[W-1:0];
        num_a[k+1] <= {num_a[k][W-2:0], 1'b0};
        den_a[k+1] <= den_a[k];
        quo_a[k+1] <= {quo_a[k][W-2:0], ge};
        pay_a[k+1] <= pay_a[k];
      end
    end
  end

  assign v_out = vld_a[W];
  assign q_out = quo_a[W];
  assign p_out = pay_a[W];

endmodule

// ===== src/bpc_temp.sv =====
module bpc_temp
  import bpc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic v_in,
  input  in_t  in_data,
  input  cal_t cal,
  output tmp_t tmp
);

  localparam int unsigned PW = DataW + 19 + 2;

  logic        va, vb;
  logic [31:0] ma, ab, db;
  logic [18:0] upa, upb;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (adv) begin
      va <= v_in;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ma  <= mul(zx16(in_data.raw_temperature) - zx16(cal.toff), zx16(cal.slope));
      upa <= in_data.raw_pressure;
      ab  <= asr(ma, 5'd15);
      db  <= asr(ma, 5'd15) + sx16(cal.dterm);
      upb <= upa;
    end
  end

  logic [31:0]   nsh, nmag, dmag, q;
  logic          neg, fault, dv;
  logic [PW-1:0] pay_in, pay_out;

  assign nsh    = sx16(cal.numer) << 11;
  assign neg    = nsh[31] ^ db[31];
  assign nmag   = nsh[31] ? (32'd0 - nsh) : nsh;
  assign dmag   = db[31] ? (32'd0 - db) : db;
  assign fault  = (db == 32'd0);
  assign pay_in = {ab, upb, neg, fault};

  bpc_div #(.W(DataW), .PW(PW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .v_in  (vb),
    .n_in  (nmag),
    .d_in  (dmag),
    .p_in  (pay_in),
    .v_out (dv),
    .q_out (q),
    .p_out (pay_out)
  );

  logic [31:0] d_a, qs, full;
  logic [18:0] d_up;
  logic        d_neg, d_fault;

  assign {d_a, d_up, d_neg, d_fault} = pay_out;
  assign qs   = d_neg ? (32'd0 - q) : q;
  assign full = d_a + qs;

  always_ff @(posedge clk) begin
    if (rst) begin
      tmp.vld <= 1'b0;
    end else if (adv) begin
      tmp.vld <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tmp.full  <= full;
      tmp.b6    <= full - TEMP_BIAS;
      tmp.up    <= d_up;
      tmp.fault <= d_fault;
    end
  end

endmodule

// ===== src/bpc_press.sv =====
module bpc_press
  import bpc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  tmp_t tmp,
  input  cal_t cal,
  output logic v_out,
  output out_t out_data
);

  logic        ve, vf, vg, vh, vi, vj, vl, vm;
  logic [31:0] e_sq, e_ol, e_sl, e_full;
  logic [18:0] e_up, f_up, g_up, h_up, i_up;
  logic        e_fault, f_fault, g_fault, h_fault, i_fault, j_fault;
  logic [31:0] f_sq, f_bo, f_as, f_full;
  logic [31:0] g_osq, g_ssq, g_bo, g_as, g_full;
  logic [31:0] h_off, h_c, h_full;
  logic [31:0] i_den, i_off, i_full;
  logic [31:0] j_den, j_b7, j_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0; vf <= 1'b0; vg <= 1'b0; vh <= 1'b0;
      vi <= 1'b0; vj <= 1'b0;
    end else if (adv) begin
      ve <= tmp.vld; vf <= ve; vg <= vf; vh <= vg; vi <= vh; vj <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_sq    <= mul(tmp.b6, tmp.b6);
      e_ol    <= mul(sx16(cal.olin), tmp.b6);
      e_sl    <= mul(sx16(cal.slin), tmp.b6);
      e_full  <= tmp.full;
      e_up    <= tmp.up;
      e_fault <= tmp.fault;

      f_sq    <= asr(e_sq, 5'd12);
      f_bo    <= asr(e_ol, 5'd11);
      f_as    <= asr(e_sl, 5'd13);
      f_full  <= e_full;
      f_up    <= e_up;
      f_fault <= e_fault;

      g_osq   <= mul(sx16(cal.osq), f_sq);
      g_ssq   <= mul(sx16(cal.ssq), f_sq);
      g_bo    <= f_bo;
      g_as    <= f_as;
      g_full  <= f_full;
      g_up    <= f_up;
      g_fault <= f_fault;

      h_off   <= asr(((mul(sx16(cal.base), 32'd4) + asr(g_osq, 5'd11) + g_bo) << cal.oss)
                     + 32'd2, 5'd2);
      h_c     <= asr(g_as + asr(g_ssq, 5'd16) + 32'd2, 5'd2);
      h_full  <= g_full;
      h_up    <= g_up;
      h_fault <= g_fault;

      i_den   <= mul(zx16(cal.scale), h_c + SCALE_BIAS);
      i_off   <= h_off;
      i_full  <= h_full;
      i_up    <= h_up;
      i_fault <= h_fault;

      j_den   <= i_den >> 15;
      j_b7    <= mul({13'd0, i_up} - i_off, QUOT_BASE >> cal.oss);
      j_full  <= i_full;
      j_fault <= i_fault | ((i_den >> 15) == 32'd0);
    end
  end

  logic [31:0] n2, q2, k_full;
  logic        post, dv, k_fault, k_post;

  assign post = (j_b7 >= SIGN_BIT);
  assign n2   = post ? j_b7 : (j_b7 << 1);

  bpc_div #(.W(DataW), .PW(DataW + 2)) u_div (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .v_in  (vj),
    .n_in  (n2),
    .d_in  (j_den),
    .p_in  ({j_full, j_fault, post}),
    .v_out (dv),
    .q_out (q2),
    .p_out ({k_full, k_fault, k_post})
  );

  logic [31:0] p, pa;
  logic [31:0] l_aa, l_b, l_p, l_full;
  logic        l_fault;
  logic [31:0] m_a3, m_b, m_p, m_full;
  logic        m_fault;
  logic [31:0] pfin, tfull;

  assign p  = k_post ? (q2 << 1) : q2;
  assign pa = asr(p, 5'd8);

  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= 1'b0; vm <= 1'b0; v_out <= 1'b0;
    end else if (adv) begin
      vl <= dv; vm <= vl; v_out <= vm;
    end
  end

  assign pfin  = m_p + asr(asr(m_a3, 5'd16) + m_b + CORR_CONST, 5'd4);
  assign tfull = asr(m_full + 32'd8, 5'd4);

  always_ff @(posedge clk) begin
    if (adv) begin
      l_aa    <= mul(pa, pa);
      l_b     <= mul(CORR_LIN, p);
      l_p     <= p;
      l_full  <= k_full;
      l_fault <= k_fault;

      m_a3    <= mul(l_aa, CORR_SQ);
      m_b     <= asr(l_b, 5'd16);
      m_p     <= l_p;
      m_full  <= l_full;
      m_fault <= l_fault;

      out_data.divide_fault       <= m_fault;
      out_data.temperature_tenths <= m_fault ? 16'sd0 : $signed(tfull[15:0]);
      out_data.pressure_pa        <= m_fault ? 32'sd0 : $signed(pfin);
    end
  end

endmodule
